>>> hdl/bbsf_pkg.sv
package bbsf_pkg;

   localparam int BYTE_W    = 8;
   localparam int CAP_W     = 11;
   localparam int OFS_W     = 10;
   localparam int TOTAL_W   = 32;
   localparam int DEPTH_DEF = 1024;

   localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_POP   = 2'd1,
      OP_PEEK  = 2'd2,
      OP_CLOSE = 2'd3
   } op_type;

   // everything a response carries except the byte from the store
   typedef struct packed {
      logic               ok;
      logic               use_rdata;
      logic [CAP_W-1:0]   fill_level;
      logic [CAP_W-1:0]   space_left;
      logic               input_closed;
      logic               end_of_stream;
      logic [TOTAL_W-1:0] total_written;
      logic [TOTAL_W-1:0] total_read;
   } meta_type;

endpackage

>>> hdl/bounded_byte_stream_fifo.sv
// Bounded byte FIFO. Each request beat is a write, pop, peek at an offset from the head,
// or end-of-input mark, and yields exactly one response beat with the byte, an ok flag,
// fill level, space left, closed and end-of-stream flags and 32-bit written/read totals.
// One beat per clock is sustained in both directions while rsp_ready is high. A response
// passes the read stage, with the registered read of the byte store, and the output stage.
// Writes beyond min(capacity, DEPTH) bytes are dropped with ok low; pops or peeks past the
// stored data return ok low and a zero byte. Write csr_wr_data/csr_wr_en only while idle.
module bounded_byte_stream_fifo
   import bbsf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_operation,
   input  logic [BYTE_W-1:0]  req_data_byte,
   input  logic [OFS_W-1:0]   req_peek_offset,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_ok,
   output logic [CAP_W-1:0]   rsp_fill_level,
   output logic [CAP_W-1:0]   rsp_space_left,
   output logic               rsp_input_closed,
   output logic               rsp_end_of_stream,
   output logic [TOTAL_W-1:0] rsp_total_written,
   output logic [TOTAL_W-1:0] rsp_total_read,
   input  logic               csr_wr_en,
   input  logic [CAP_W-1:0]   csr_wr_data
);

   localparam int AW = $clog2(DEPTH);

   logic              ram_wr_en, ram_rd_en;
   logic [AW-1:0]     ram_wr_addr, ram_rd_addr;
   logic [BYTE_W-1:0] ram_wr_data, ram_rd_data;
   logic              s1_valid, s1_advance;
   meta_type          s1_meta;

   bbsf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bbsf_ctrl #(
      .DEPTH (DEPTH)
   ) u_ctrl (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_operation   (req_operation),
      .req_data_byte   (req_data_byte),
      .req_peek_offset (req_peek_offset),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .ram_wr_en       (ram_wr_en),
      .ram_wr_addr     (ram_wr_addr),
      .ram_wr_data     (ram_wr_data),
      .ram_rd_en       (ram_rd_en),
      .ram_rd_addr     (ram_rd_addr),
      .s1_valid        (s1_valid),
      .s1_meta         (s1_meta),
      .s1_advance      (s1_advance)
   );

   bbsf_rsp u_rsp (
      .clock             (clock),
      .reset             (reset),
      .s1_valid          (s1_valid),
      .s1_meta           (s1_meta),
      .ram_rd_data       (ram_rd_data),
      .s1_advance        (s1_advance),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_ok            (rsp_ok),
      .rsp_fill_level    (rsp_fill_level),
      .rsp_space_left    (rsp_space_left),
      .rsp_input_closed  (rsp_input_closed),
      .rsp_end_of_stream (rsp_end_of_stream),
      .rsp_total_written (rsp_total_written),
      .rsp_total_read    (rsp_total_read)
   );

endmodule

>>> hdl/bbsf_ram.sv
module bbsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hdl/bbsf_ctrl.sv
module bbsf_ctrl
   import bbsf_pkg::*;
#(
   parameter int DEPTH = DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  logic [1:0]               req_operation,
   input  logic [BYTE_W-1:0]        req_data_byte,
   input  logic [OFS_W-1:0]         req_peek_offset,
   input  logic                     csr_wr_en,
   input  logic [CAP_W-1:0]         csr_wr_data,
   output logic                     ram_wr_en,
   output logic [$clog2(DEPTH)-1:0] ram_wr_addr,
   output logic [BYTE_W-1:0]        ram_wr_data,
   output logic                     ram_rd_en,
   output logic [$clog2(DEPTH)-1:0] ram_rd_addr,
   output logic                     s1_valid,
   output meta_type                 s1_meta,
   input  logic                     s1_advance
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int KW = (CW > CAP_W) ? CW : CAP_W;
   localparam int SW = KW + 1;

   logic [AW-1:0]      head_ff, head_in;
   logic [CW-1:0]      fill_ff, fill_in;
   logic [TOTAL_W-1:0] wr_total_ff, wr_total_in;
   logic [TOTAL_W-1:0] rd_total_ff, rd_total_in;
   logic               closed_ff, closed_in;
   logic [CAP_W-1:0]   cap_ff, cap_in;
   logic               s1_valid_ff, s1_valid_in;
   meta_type           s1_meta_ff, s1_meta_in;

   logic               accept;
   op_type             op;
   logic [KW-1:0]      eff_cap, cap_k, depth_k, fill_k, ofs_k, fill_next_k;
   logic               can_write, has_byte, peek_hit;
   meta_type           meta;

   // circular position of an offset from a base slot
   function automatic logic [AW-1:0] slot_of(logic [AW-1:0] base, logic [KW-1:0] ofs);
      logic [SW-1:0] sum;
      begin
         sum = SW'(base) + SW'(ofs);
         if (sum >= SW'(DEPTH)) begin
            sum = sum - SW'(DEPTH);
         end
         return sum[AW-1:0];
      end
   endfunction

   assign req_ready = !s1_valid_ff || s1_advance;
   assign accept    = req_valid && req_ready;
   assign op        = op_type'(req_operation);

   always_comb begin
      cap_k     = KW'(cap_ff);
      depth_k   = KW'(DEPTH);
      eff_cap   = (cap_k > depth_k) ? depth_k : cap_k;
      fill_k    = KW'(fill_ff);
      ofs_k     = KW'(req_peek_offset);
      can_write = fill_k < eff_cap;
      has_byte  = fill_ff != '0;
      peek_hit  = ofs_k < fill_k;

      head_in     = head_ff;
      fill_in     = fill_ff;
      wr_total_in = wr_total_ff;
      rd_total_in = rd_total_ff;
      closed_in   = closed_ff;
      cap_in      = csr_wr_en ? csr_wr_data : cap_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = slot_of(head_ff, fill_k);
      ram_wr_data = req_data_byte;
      ram_rd_en   = 1'b0;
      ram_rd_addr = head_ff;

      meta           = '0;
      meta.ok        = 1'b0;
      meta.use_rdata = 1'b0;

      if (accept) begin
         unique case (op)
            OP_WRITE: begin
               if (can_write) begin
                  ram_wr_en   = 1'b1;
                  fill_in     = fill_ff + 1'b1;
                  wr_total_in = wr_total_ff + 1'b1;
                  meta.ok     = 1'b1;
               end
            end
            OP_POP: begin
               if (has_byte) begin
                  ram_rd_en      = 1'b1;
                  head_in        = slot_of(head_ff, KW'(1));
                  fill_in        = fill_ff - 1'b1;
                  rd_total_in    = rd_total_ff + 1'b1;
                  meta.ok        = 1'b1;
                  meta.use_rdata = 1'b1;
               end
            end
            OP_PEEK: begin
               if (peek_hit) begin
                  ram_rd_en      = 1'b1;
                  ram_rd_addr    = slot_of(head_ff, ofs_k);
                  meta.ok        = 1'b1;
                  meta.use_rdata = 1'b1;
               end
            end
            OP_CLOSE: begin
               closed_in = 1'b1;
               meta.ok   = 1'b1;
            end
         endcase
      end

      fill_next_k        = KW'(fill_in);
      meta.fill_level    = CAP_W'(fill_in);
      meta.space_left    = (fill_next_k < eff_cap) ? CAP_W'(eff_cap - fill_next_k) : '0;
      meta.input_closed  = closed_in;
      meta.end_of_stream = closed_in && (fill_in == '0);
      meta.total_written = wr_total_in;
      meta.total_read    = rd_total_in;

      s1_meta_in  = accept ? meta : s1_meta_ff;
      s1_valid_in = accept ? 1'b1 : (s1_advance ? 1'b0 : s1_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         fill_ff     <= '0;
         wr_total_ff <= '0;
         rd_total_ff <= '0;
         closed_ff   <= 1'b0;
         cap_ff      <= CAP_RESET;
         s1_valid_ff <= 1'b0;
      end else begin
         head_ff     <= head_in;
         fill_ff     <= fill_in;
         wr_total_ff <= wr_total_in;
         rd_total_ff <= rd_total_in;
         closed_ff   <= closed_in;
         cap_ff      <= cap_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_meta_ff <= s1_meta_in;
   end

   assign s1_valid = s1_valid_ff;
   assign s1_meta  = s1_meta_ff;

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      KW'(fill_ff) <= KW'(DEPTH))
      else $error("fill count beyond depth");

   a_one_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_wr_en && ram_rd_en))
      else $error("store written and read for one beat");

   a_write_grows: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> fill_ff == CW'($past(fill_ff) + 1'b1))
      else $error("accepted write did not raise fill count");

   a_stage_holds: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s1_advance |=> s1_valid_ff && $stable(s1_meta_ff))
      else $error("stalled beat lost in read stage");

endmodule

>>> hdl/bbsf_rsp.sv
module bbsf_rsp
   import bbsf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               s1_valid,
   input  meta_type           s1_meta,
   input  logic [BYTE_W-1:0]  ram_rd_data,
   output logic               s1_advance,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [BYTE_W-1:0]  rsp_out_byte,
   output logic               rsp_ok,
   output logic [CAP_W-1:0]   rsp_fill_level,
   output logic [CAP_W-1:0]   rsp_space_left,
   output logic               rsp_input_closed,
   output logic               rsp_end_of_stream,
   output logic [TOTAL_W-1:0] rsp_total_written,
   output logic [TOTAL_W-1:0] rsp_total_read
);

   logic              rsp_valid_ff, rsp_valid_in;
   meta_type          meta_ff, meta_in;
   logic [BYTE_W-1:0] byte_ff, byte_in;
   logic              load;

   assign s1_advance = !rsp_valid_ff || rsp_ready;
   assign load       = s1_valid && s1_advance;

   always_comb begin
      meta_in      = load ? s1_meta : meta_ff;
      byte_in      = load ? (s1_meta.use_rdata ? ram_rd_data : '0) : byte_ff;
      rsp_valid_in = load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      meta_ff <= meta_in;
      byte_ff <= byte_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = byte_ff;
   assign rsp_ok            = meta_ff.ok;
   assign rsp_fill_level    = meta_ff.fill_level;
   assign rsp_space_left    = meta_ff.space_left;
   assign rsp_input_closed  = meta_ff.input_closed;
   assign rsp_end_of_stream = meta_ff.end_of_stream;
   assign rsp_total_written = meta_ff.total_written;
   assign rsp_total_read    = meta_ff.total_read;

   a_eos_closed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && meta_ff.end_of_stream |-> meta_ff.input_closed)
      else $error("end of stream without closed input");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !meta_ff.ok |-> byte_ff == '0)
      else $error("refused beat carries a byte");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      load |=> rsp_valid_ff)
      else $error("loaded beat not presented");

endmodule
